// ===== hw/rtl/fwh_pkg.sv =====
package fwh_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned MaxBinsDefault   = 256;
  localparam int unsigned CountBitsDefault = 32;

  // Field widths
  localparam int unsigned DataW   = 32;
  localparam int unsigned BinIdxW = 8;
  localparam int unsigned OpW     = 2;
  localparam int unsigned StatusW = 3;

  // Stream packing
  localparam int unsigned InDataW  = 40;   // value, read_bin
  localparam int unsigned InUserW  = OpW;  // op
  localparam int unsigned OutDataW = 104;  // bin_index, bin_count, bin_low, bin_high
  localparam int unsigned OutUserW = StatusW;

  // Divider: one quotient bit per step
  localparam int unsigned DivSteps = DataW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  // Product of read index and bin width
  localparam int unsigned ProdW = BinIdxW + DataW;

  // Register reset values
  localparam logic signed [DataW-1:0] RangeStartReset = 32'sd0;
  localparam logic signed [DataW-1:0] RangeEndReset   = 32'sd255;
  localparam logic [DataW-1:0]        BinWidthReset   = 32'd1;

  typedef enum logic [1:0] {
    REG_RANGE_START = 2'd0,
    REG_RANGE_END   = 2'd1,
    REG_BIN_WIDTH   = 2'd2
  } cfg_reg_e;

  typedef enum logic [OpW-1:0] {
    OP_ADD      = 2'd0,
    OP_REMOVE   = 2'd1,
    OP_READ     = 2'd2,
    OP_READ_ALT = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 3'd0,
    ST_BELOW = 3'd1,
    ST_ABOVE = 3'd2,
    ST_EMPTY = 3'd3,
    ST_CAP   = 3'd4
  } status_e;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_PREP  = 8'b0000_0100,
    S_DIV   = 8'b0000_1000,
    S_CHK   = 8'b0001_0000,
    S_RDW   = 8'b0010_0000,
    S_UPD   = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_e;

endpackage

// ===== hw/rtl/fixed_width_histogram.sv =====
// Fixed-width bin histogram over a signed 32-bit range. The range
// [range_start, range_end] is cut into bins of bin_width values from
// range_start; the last bin stops at range_end. Each input item adds a
// value, removes one, or reads a bin, and gives exactly one result item
// with the bin, its count and its bounds, plus a status. Counts saturate.
// One item is worked on at a time. An in-range add or remove finds the
// bin index with a shared restoring divider that produces one quotient
// bit per cycle, followed by a read-modify-write of the count memory. A
// read does one index-by-width multiply, then the memory read, and an
// out-of-range value goes to the result straight from the range check.
// After reset the count memory is cleared one entry per cycle, during
// which no item is accepted; configuration writes are taken at all times
// and never clear the counts.
module fixed_width_histogram
  import fwh_pkg::*;
#(
  parameter int unsigned MAX_BINS   = MaxBinsDefault,
  parameter int unsigned COUNT_BITS = CountBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,

  // Configuration writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [DataW-1:0]    cfg_data_i,

  // Input items
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // value[31:0], read_bin[39:32]
  input  logic [InUserW-1:0]  s_axis_tuser,   // op[1:0]

  // Result items
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // bin_index[7:0], bin_count[39:8],
                                              // bin_low[71:40], bin_high[103:72]
  output logic [OutUserW-1:0] m_axis_tuser    // status[2:0]
);

  localparam int unsigned IdxW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam logic [IdxW-1:0]       LastAddr = IdxW'(MAX_BINS - 1);
  localparam logic [DataW-1:0]      BinsLim  = DataW'(MAX_BINS);
  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  // Configuration registers
  logic signed [DataW-1:0] start_q, end_q;
  logic [DataW-1:0]        width_q;   // zero is held as one

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= RangeStartReset;
      end_q   <= RangeEndReset;
      width_q <= BinWidthReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_RANGE_START: start_q <= cfg_data_i;
        REG_RANGE_END:   end_q   <= cfg_data_i;
        REG_BIN_WIDTH:   width_q <= (cfg_data_i == '0) ? DataW'(1) : cfg_data_i;
        default: ;
      endcase
    end
  end

  // Count memory
  logic [COUNT_BITS-1:0] mem [MAX_BINS];
  logic                  mem_we, mem_re;
  logic [IdxW-1:0]       mem_waddr, mem_raddr;
  logic [COUNT_BITS-1:0] mem_wdata, mem_rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem[mem_raddr];
    end
  end

  // Control and datapath registers
  state_e                  state_q, state_d;
  logic [IdxW-1:0]         clr_q, clr_d;
  logic                    out_valid_q, out_valid_d;
  op_e                     op_q, op_d;
  logic signed [DataW-1:0] val_q, val_d;
  logic [BinIdxW-1:0]      rbin_q, rbin_d;
  logic [DataW-1:0]        rem_q, rem_d;
  logic [DataW-1:0]        quo_q, quo_d;
  logic [DivCntW-1:0]      step_q, step_d;
  logic [ProdW-1:0]        prod_q, prod_d;
  logic [DataW-1:0]        idx_q, idx_d;
  logic signed [DataW-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [DataW-1:0]        cnt_q, cnt_d;
  status_e                 st_q, st_d;
  logic [OutDataW-1:0]     out_data_q, out_data_d;
  logic [OutUserW-1:0]     out_user_q, out_user_d;

  // Shared divider step and helpers
  logic [DataW:0]          div_sh;
  logic                    div_ge;
  logic [DataW:0]          div_sub;
  logic                    is_read;
  logic [DataW-1:0]        span;
  logic signed [DataW+1:0] hi_sum;
  logic [COUNT_BITS-1:0]   new_cnt;
  logic [63:0]             cnt_ext;

  assign div_sh  = {rem_q, quo_q[DataW-1]};
  assign div_ge  = div_sh >= {1'b0, width_q};
  assign div_sub = div_sh - {1'b0, width_q};
  assign is_read = (op_q == OP_READ) || (op_q == OP_READ_ALT);
  assign span    = end_q - start_q;
  assign hi_sum  = $signed({{2{lo_q[DataW-1]}}, lo_q}) + $signed({2'b00, width_q})
                   - (DataW+2)'(1);

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q;
    op_d        = op_q;
    val_d       = val_q;
    rbin_d      = rbin_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    step_d      = step_q;
    prod_d      = prod_q;
    idx_d       = idx_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    cnt_d       = cnt_q;
    st_d        = st_q;
    out_data_d  = out_data_q;
    out_user_d  = out_user_q;
    mem_we      = 1'b0;
    mem_waddr   = clr_q;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = quo_q[IdxW-1:0];
    new_cnt     = mem_rdata_q;
    cnt_ext     = '0;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        clr_d  = clr_q + IdxW'(1);
        if (clr_q == LastAddr) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (s_axis_tvalid) begin
          op_d    = op_e'(s_axis_tuser);
          val_d   = s_axis_tdata[DataW-1:0];
          rbin_d  = s_axis_tdata[DataW +: BinIdxW];
          state_d = S_PREP;
        end
      end

      // Range checks, or the index-by-width product for a read
      S_PREP: begin
        idx_d = '0;
        lo_d  = '0;
        hi_d  = '0;
        cnt_d = '0;
        if (is_read) begin
          prod_d  = ProdW'(rbin_q) * ProdW'(width_q);
          state_d = S_CHK;
        end else if (val_q < start_q) begin
          st_d    = ST_BELOW;
          state_d = S_FIN;
        end else if (val_q > end_q) begin
          st_d    = ST_ABOVE;
          state_d = S_FIN;
        end else begin
          rem_d   = '0;
          quo_d   = val_q - start_q;
          step_d  = '0;
          state_d = S_DIV;
        end
      end

      // One quotient bit per cycle
      S_DIV: begin
        rem_d  = div_ge ? div_sub[DataW-1:0] : div_sh[DataW-1:0];
        quo_d  = {quo_q[DataW-2:0], div_ge};
        step_d = step_q + DivCntW'(1);
        if (step_q == DivCntW'(DivSteps - 1)) begin
          state_d = S_CHK;
        end
      end

      // Capacity check, lower bound, count read
      S_CHK: begin
        if (is_read) begin
          if ((end_q < start_q) || (prod_q > {{BinIdxW{1'b0}}, span}) ||
              ({{(DataW-BinIdxW){1'b0}}, rbin_q} >= BinsLim)) begin
            st_d    = ST_CAP;
            state_d = S_FIN;
          end else begin
            idx_d     = {{(DataW-BinIdxW){1'b0}}, rbin_q};
            lo_d      = start_q + prod_q[DataW-1:0];
            mem_re    = 1'b1;
            mem_raddr = IdxW'(rbin_q);
            state_d   = S_RDW;
          end
        end else if (quo_q >= BinsLim) begin
          st_d    = ST_CAP;
          state_d = S_FIN;
        end else begin
          idx_d     = quo_q;
          lo_d      = val_q - rem_q;
          mem_re    = 1'b1;
          mem_raddr = quo_q[IdxW-1:0];
          state_d   = S_RDW;
        end
      end

      // Upper bound, clipped to the range end
      S_RDW: begin
        hi_d    = (hi_sum > $signed({{2{end_q[DataW-1]}}, end_q})) ? end_q
                                                                 : hi_sum[DataW-1:0];
        state_d = S_UPD;
      end

      // Count update and write-back
      S_UPD: begin
        st_d      = ST_OK;
        mem_waddr = idx_q[IdxW-1:0];
        if (is_read) begin
          new_cnt = mem_rdata_q;
        end else if (op_q == OP_ADD) begin
          new_cnt = (mem_rdata_q == CountMax) ? mem_rdata_q
                                              : mem_rdata_q + COUNT_BITS'(1);
          mem_we  = 1'b1;
        end else if (mem_rdata_q == '0) begin
          new_cnt = '0;
          st_d    = ST_EMPTY;
        end else begin
          new_cnt = mem_rdata_q - COUNT_BITS'(1);
          mem_we  = 1'b1;
        end
        mem_wdata = new_cnt;
        cnt_ext   = 64'(new_cnt);
        cnt_d     = cnt_ext[DataW-1:0];
        state_d   = S_FIN;
      end

      // Hand the result to the output register
      S_FIN: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = {hi_q, lo_q, cnt_q, idx_q[BinIdxW-1:0]};
          out_user_d  = st_q;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    val_q      <= val_d;
    rbin_q     <= rbin_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    step_q     <= step_d;
    prod_q     <= prod_d;
    idx_q      <= idx_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    cnt_q      <= cnt_d;
    st_q       <= st_d;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
  end

  // Checks
  a_no_intake_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("item accepted while another is in flight");

  a_mem_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_CLEAR || state_q == S_UPD))
    else $error("count memory written outside clear or update");

  a_div_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q < width_q))
    else $error("divider remainder not below bin width");

  a_empty_zero_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == ST_EMPTY) |-> (m_axis_tdata[39:8] == '0))
    else $error("empty-bin removal reports a non-zero count");

  a_error_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == ST_BELOW || m_axis_tuser == ST_ABOVE ||
                       m_axis_tuser == ST_CAP)) |-> (m_axis_tdata == '0))
    else $error("error result carries non-zero fields");

endmodule
